### sv/mfsf_pkg.sv
// Package with shared constants, types and codes of the MPEG-2 frame start finder.
`default_nettype none

package mfsf_pkg;

  // Width of the byte position counter and of the reported header offset.
  localparam int OFFSET_WIDTH = 16;
  localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = {OFFSET_WIDTH{1'b1}};

  // Start code matching.
  localparam logic [23:0] HIST_ONES  = 24'hFF_FFFF;
  localparam logic [23:0] PREFIX     = 24'h00_0001;
  localparam logic [7:0]  CODE_SEQ   = 8'hB3;
  localparam logic [7:0]  CODE_GROUP = 8'hB8;
  localparam logic [7:0]  CODE_PIC   = 8'h00;

  // Start position of the three-byte start code prefix, counted back from the code byte.
  localparam logic [OFFSET_WIDTH-1:0] PREFIX_LEN = OFFSET_WIDTH'(3);

  // Picture coding types.
  typedef enum logic [1:0] {
    FT_NONE = 2'd0,
    FT_I    = 2'd1,
    FT_P    = 2'd2,
    FT_B    = 2'd3
  } picture_type_t;

  // Search phases, one-hot.
  typedef enum logic [5:0] {
    PH_SEQ   = 6'b000001,
    PH_GROUP = 6'b000010,
    PH_PIC   = 6'b000100,
    PH_SKIP  = 6'b001000,
    PH_TYPE  = 6'b010000,
    PH_IDLE  = 6'b100000
  } phase_t;

  // One result item.
  typedef struct packed {
    picture_type_t           picture_type;
    logic [OFFSET_WIDTH-1:0] header_offset;
  } result_t;

endpackage

`default_nettype wire

### sv/mpeg2_frame_start_finder.sv
// Top level of the MPEG-2 frame start finder: scanner stage followed by the output register.
`default_nettype none

// The block scans one buffer of an MPEG-2 video elementary stream, one byte per input
// transfer, with last_byte marking the final byte of the buffer. It looks for a sequence
// header code, then a group-of-pictures code, then a picture start code, each being a
// code byte right after 00 00 01; the history is cleared after every matched code. The
// picture coding type is taken from bits 5..3 of the second byte after the picture code.
// Exactly one result transfer comes out per buffer: an I, P or B type together with the
// byte offset of the sequence header's first zero byte, or type 0 with offset 0 when the
// type is something else or the buffer ends first. The offset counter saturates at its
// maximum. A new byte is accepted in every cycle unless the stall below holds it. Each byte
// waits in the input register, where the start code match and state update are done, and
// a result passes from there into the output register, which drives out_valid. The output
// register lets the scanner keep taking bytes while a result waits to be taken; only a
// byte that itself produces a result stalls while the previous result is still held.
module mpeg2_frame_start_finder (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    data_byte,
  input  wire logic                          last_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         picture_type,
  output logic [mfsf_pkg::OFFSET_WIDTH-1:0]  header_offset
);

  // Result handoff between the scanner and the output register.
  logic              res_valid;
  logic              res_ready;
  mfsf_pkg::result_t res;

  mfsf_scanner u_scanner (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  mfsf_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .picture_type  (picture_type),
    .header_offset (header_offset)
  );

endmodule

`default_nettype wire

### sv/mfsf_scanner.sv
// Input register, start code search state and result decision for one byte per cycle when no waiting result stalls it.
`default_nettype none

module mfsf_scanner (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output mfsf_pkg::result_t      res
);

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // Search state.
  logic [23:0]                      hist;
  mfsf_pkg::phase_t                 phase;
  logic [mfsf_pkg::OFFSET_WIDTH-1:0] pos;
  logic [mfsf_pkg::OFFSET_WIDTH-1:0] seq_start;
  logic                             answer_given;

  logic [23:0]                      hist_next;
  mfsf_pkg::phase_t                 phase_next;
  logic [mfsf_pkg::OFFSET_WIDTH-1:0] pos_next;
  logic [mfsf_pkg::OFFSET_WIDTH-1:0] seq_start_next;
  logic                             answer_given_next;

  logic [7:0]  want;
  logic        searching;
  logic        matched;
  logic [2:0]  type_field;
  logic        has_result;
  logic        s1_go;

  always_comb begin
    want      = mfsf_pkg::CODE_PIC;
    searching = 1'b0;
    unique case (phase)
      mfsf_pkg::PH_SEQ: begin
        want      = mfsf_pkg::CODE_SEQ;
        searching = 1'b1;
      end
      mfsf_pkg::PH_GROUP: begin
        want      = mfsf_pkg::CODE_GROUP;
        searching = 1'b1;
      end
      mfsf_pkg::PH_PIC: begin
        want      = mfsf_pkg::CODE_PIC;
        searching = 1'b1;
      end
      default: begin
        want      = mfsf_pkg::CODE_PIC;
        searching = 1'b0;
      end
    endcase
  end

  assign matched    = searching && (hist == mfsf_pkg::PREFIX) && (s1_byte == want);
  assign type_field = s1_byte[5:3];

  // A result is due on the type byte, or on the last byte when none was given.
  assign has_result = (phase == mfsf_pkg::PH_TYPE) || (s1_last && !answer_given);
  assign s1_go      = s1_valid && (!has_result || res_ready);
  assign in_ready   = !s1_valid || s1_go;
  assign res_valid  = s1_valid && has_result;

  always_comb begin
    res.picture_type  = mfsf_pkg::FT_NONE;
    res.header_offset = '0;
    if ((phase == mfsf_pkg::PH_TYPE) && (type_field != 3'd0) && !type_field[2]) begin
      res.picture_type  = mfsf_pkg::picture_type_t'(type_field[1:0]);
      res.header_offset = seq_start;
    end
  end

  always_comb begin
    hist_next         = hist;
    phase_next        = phase;
    seq_start_next    = seq_start;
    answer_given_next = answer_given;
    pos_next          = (pos == mfsf_pkg::OFFSET_MAX) ? pos : pos + 1'b1;

    unique case (phase)
      mfsf_pkg::PH_SEQ, mfsf_pkg::PH_GROUP, mfsf_pkg::PH_PIC: begin
        if (matched) begin
          hist_next = mfsf_pkg::HIST_ONES;
          if (phase == mfsf_pkg::PH_SEQ) begin
            seq_start_next = (pos == mfsf_pkg::OFFSET_MAX) ? mfsf_pkg::OFFSET_MAX
                                                           : pos - mfsf_pkg::PREFIX_LEN;
            phase_next     = mfsf_pkg::PH_GROUP;
          end else if (phase == mfsf_pkg::PH_GROUP) begin
            phase_next = mfsf_pkg::PH_PIC;
          end else begin
            phase_next = mfsf_pkg::PH_SKIP;
          end
        end else begin
          hist_next = {hist[15:0], s1_byte};
        end
      end
      mfsf_pkg::PH_SKIP: begin
        phase_next = mfsf_pkg::PH_TYPE;
      end
      mfsf_pkg::PH_TYPE: begin
        answer_given_next = 1'b1;
        phase_next        = mfsf_pkg::PH_IDLE;
      end
      default: begin
        phase_next = phase;
      end
    endcase

    // The end of a buffer returns everything to its reset value.
    if (s1_last) begin
      hist_next         = mfsf_pkg::HIST_ONES;
      phase_next        = mfsf_pkg::PH_SEQ;
      pos_next          = '0;
      seq_start_next    = '0;
      answer_given_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist         <= mfsf_pkg::HIST_ONES;
      phase        <= mfsf_pkg::PH_SEQ;
      pos          <= '0;
      seq_start    <= '0;
      answer_given <= 1'b0;
    end else if (s1_go) begin
      hist         <= hist_next;
      phase        <= phase_next;
      pos          <= pos_next;
      seq_start    <= seq_start_next;
      answer_given <= answer_given_next;
    end
  end

  // Once the answer is out, the search waits for the end of the buffer.
  a_answer_idle: assert property (@(posedge clk) disable iff (rst)
    answer_given |-> (phase == mfsf_pkg::PH_IDLE))
    else $error("answer given but search not idle");

  // Between the picture code and the type byte the history stays cleared.
  a_hist_clear: assert property (@(posedge clk) disable iff (rst)
    ((phase == mfsf_pkg::PH_SKIP) || (phase == mfsf_pkg::PH_TYPE))
      |-> (hist == mfsf_pkg::HIST_ONES))
    else $error("history not cleared after picture code");

  // The last byte of a buffer restarts the search from its beginning.
  a_buffer_restart: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last) |=> ((phase == mfsf_pkg::PH_SEQ) && (pos == '0) && !answer_given))
    else $error("state not cleared after last byte");

endmodule

`default_nettype wire

### sv/mfsf_out_reg.sv
// Output register that holds one result until it is taken downstream.
`default_nettype none

module mfsf_out_reg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              res_valid,
  output logic                                   res_ready,
  input  wire mfsf_pkg::result_t                 res,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [1:0]                             picture_type,
  output logic [mfsf_pkg::OFFSET_WIDTH-1:0]      header_offset
);

  mfsf_pkg::result_t held;

  assign res_ready     = !out_valid || out_ready;
  assign picture_type  = held.picture_type;
  assign header_offset = held.header_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      held <= res;
    end
  end

  // A result that reports no picture never carries an offset.
  a_none_no_offset: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (picture_type == mfsf_pkg::FT_NONE)) |-> (header_offset == '0))
    else $error("offset reported without a picture type");

  // A result handed over from the scanner shows up at the output next cycle.
  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |=> out_valid)
    else $error("result transfer lost");

  // The output register never takes a new result over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !res_ready)
    else $error("waiting result could be overwritten");

endmodule

`default_nettype wire
